// ----- src/rbsi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared constants and register codes for the ray/box slab intersect unit.
// ----------------------------------------------------------------------------
package rbsi_pkg;

  localparam int FRAC_BITS = 16;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_HALF_X   = 3'd3,
    REG_HALF_Y   = 3'd4,
    REG_HALF_Z   = 3'd5
  } reg_idx_t;

endpackage

// ----- src/rbsi_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined restoring divider, one quotient bit per stage, with saturation
// of the signed fixed-point quotient.
// ----------------------------------------------------------------------------
module rbsi_div #(
  parameter int COORD_BITS = 32
) (
  input  logic                                          clk,
  input  logic [COORD_BITS+rbsi_pkg::FRAC_BITS:0]       num_mag,
  input  logic [COORD_BITS-1:0]                         den_mag,
  input  logic                                          neg,
  output logic signed [COORD_BITS-1:0]                  quo
);

  localparam int W  = COORD_BITS;
  localparam int NB = COORD_BITS + rbsi_pkg::FRAC_BITS + 1;

  logic [NB-1:0] nsh [NB+1];
  logic [W-1:0]  rem [NB+1];
  logic [W:0]    q   [NB+1];
  logic          ovr [NB+1];
  logic [W-1:0]  den [NB+1];
  logic          ng  [NB+1];

  assign nsh[0] = num_mag;
  assign rem[0] = '0;
  assign q[0]   = '0;
  assign ovr[0] = 1'b0;
  assign den[0] = den_mag;
  assign ng[0]  = neg;

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [W:0] shf;
    logic       ge;
    assign shf = {rem[k], nsh[k][NB-1]};
    assign ge  = shf >= {1'b0, den[k]};
    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? W'(shf - {1'b0, den[k]}) : shf[W-1:0];
      nsh[k+1] <= {nsh[k][NB-2:0], 1'b0};
      q[k+1]   <= {q[k][W-1:0], ge};
      ovr[k+1] <= ovr[k] | q[k][W];
      den[k+1] <= den[k];
      ng[k+1]  <= ng[k];
    end
  end

  logic [W:0] lim;
  logic [W:0] qs;

  always_comb begin
    lim = ((W+1)'(1) << (W-1)) - (W+1)'(!ng[NB]);
    qs  = (ovr[NB] || (q[NB] > lim)) ? lim : q[NB];
  end

  always_ff @(posedge clk) begin
    quo <= ng[NB] ? W'(-qs) : W'(qs);
  end

endmodule

// ----- src/rbsi_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_lane
// One axis of the slab test: slab offsets, two dividers, entry/exit order.
// A zero direction turns into a containment check.
// ----------------------------------------------------------------------------
module rbsi_lane #(
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  logic signed [COORD_BITS-1:0]  center,
  input  logic [COORD_BITS-2:0]         half,
  input  logic signed [COORD_BITS-1:0]  origin,
  input  logic signed [COORD_BITS-1:0]  dir,
  output logic signed [COORD_BITS-1:0]  t_lo,
  output logic signed [COORD_BITS-1:0]  t_hi,
  output logic                          outside
);

  localparam int W  = COORD_BITS;
  localparam int NB = COORD_BITS + rbsi_pkg::FRAC_BITS + 1;
  localparam int DL = NB + 1;

  logic signed [W+1:0] e_s, hi_s, lo_s;
  logic [W:0]          hi_m, lo_m;
  logic [NB-1:0]       hi_num, lo_num;
  logic [W-1:0]        den;
  logic                hi_neg, lo_neg, fz, outs;

  always_comb begin
    e_s  = (W+2)'(center) - (W+2)'(origin);
    hi_s = e_s + $signed({3'b000, half});
    lo_s = e_s - $signed({3'b000, half});
  end

  always_ff @(posedge clk) begin
    hi_m   <= hi_s[W+1] ? (W+1)'(-hi_s) : hi_s[W:0];
    lo_m   <= lo_s[W+1] ? (W+1)'(-lo_s) : lo_s[W:0];
    hi_neg <= hi_s[W+1] ^ dir[W-1];
    lo_neg <= lo_s[W+1] ^ dir[W-1];
    den    <= dir[W-1] ? W'(-dir) : W'(dir);
    fz     <= dir == '0;
    outs   <= hi_s[W+1] || (lo_s[W+1] == 1'b0 && lo_s != '0);
  end

  assign hi_num = {hi_m, {rbsi_pkg::FRAC_BITS{1'b0}}};
  assign lo_num = {lo_m, {rbsi_pkg::FRAC_BITS{1'b0}}};

  logic signed [W-1:0] t1, t2;

  rbsi_div #(.COORD_BITS(COORD_BITS)) u_div_hi (
    .clk(clk), .num_mag(hi_num), .den_mag(den), .neg(hi_neg), .quo(t1)
  );
  rbsi_div #(.COORD_BITS(COORD_BITS)) u_div_lo (
    .clk(clk), .num_mag(lo_num), .den_mag(den), .neg(lo_neg), .quo(t2)
  );

  logic fz_d   [DL];
  logic outs_d [DL];

  always_ff @(posedge clk) begin
    fz_d[0]   <= fz;
    outs_d[0] <= outs;
    for (int i = 1; i < DL; i++) begin
      fz_d[i]   <= fz_d[i-1];
      outs_d[i] <= outs_d[i-1];
    end
  end

  localparam logic signed [W-1:0] T_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] T_MAX = {1'b0, {(W-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (fz_d[DL-1]) begin
      t_lo <= T_MIN;
      t_hi <= T_MAX;
    end else begin
      t_lo <= (t1 < t2) ? t1 : t2;
      t_hi <= (t1 < t2) ? t2 : t1;
    end
    outside <= fz_d[DL-1] & outs_d[DL-1];
  end

endmodule

// ----- src/ray_box_slab_intersect_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit
// Ray versus axis-aligned box, slab method, signed Q(COORD_BITS-16).16.
// ----------------------------------------------------------------------------
// A request is taken every clock cycle (busy stays low); results come back
// one per request, in order, with done high for one cycle and no back
// pressure. The pipeline depth is set by the per-axis dividers, which
// resolve one quotient bit per pipeline stage over COORD_BITS+17 stages.
// Box registers are written over APB and should only change while no
// request is in flight.
module ray_box_slab_intersect_unit #(
  parameter int COORD_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [((COORD_BITS > 32) ? 6 : 5)-1:0] paddr,
  input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COORD_BITS > 32) ? 64 : 32)-1:0] prdata,
  output logic                                   pready,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [COORD_BITS-1:0]           origin_x,
  input  logic signed [COORD_BITS-1:0]           origin_y,
  input  logic signed [COORD_BITS-1:0]           origin_z,
  input  logic signed [COORD_BITS-1:0]           dir_x,
  input  logic signed [COORD_BITS-1:0]           dir_y,
  input  logic signed [COORD_BITS-1:0]           dir_z,
  input  logic signed [COORD_BITS-1:0]           max_distance,
  output logic                                   done,
  output logic                                   hit,
  output logic signed [COORD_BITS-1:0]           hit_distance
);

  localparam int W   = COORD_BITS;
  localparam int AW  = (COORD_BITS > 32) ? 6 : 5;
  localparam int ASH = (COORD_BITS > 32) ? 3 : 2;
  localparam int DW  = (COORD_BITS > 32) ? 64 : 32;
  localparam int NB  = COORD_BITS + rbsi_pkg::FRAC_BITS + 1;
  localparam int LAT = NB + 5;

  // configuration
  logic [W-1:0] center_x, center_y, center_z;
  logic [W-2:0] half_x, half_y, half_z;
  rbsi_pkg::reg_idx_t widx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign widx   = rbsi_pkg::reg_idx_t'(paddr[AW-1:ASH]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      half_x   <= '0;
      half_y   <= '0;
      half_z   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        rbsi_pkg::REG_CENTER_X: center_x <= pwdata[W-1:0];
        rbsi_pkg::REG_CENTER_Y: center_y <= pwdata[W-1:0];
        rbsi_pkg::REG_CENTER_Z: center_z <= pwdata[W-1:0];
        rbsi_pkg::REG_HALF_X:   half_x   <= pwdata[W-2:0];
        rbsi_pkg::REG_HALF_Y:   half_y   <= pwdata[W-2:0];
        rbsi_pkg::REG_HALF_Z:   half_z   <= pwdata[W-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      rbsi_pkg::REG_CENTER_X: prdata = DW'(center_x);
      rbsi_pkg::REG_CENTER_Y: prdata = DW'(center_y);
      rbsi_pkg::REG_CENTER_Z: prdata = DW'(center_z);
      rbsi_pkg::REG_HALF_X:   prdata = DW'(half_x);
      rbsi_pkg::REG_HALF_Y:   prdata = DW'(half_y);
      rbsi_pkg::REG_HALF_Z:   prdata = DW'(half_z);
      default:                prdata = '0;
    endcase
  end

  // axis lanes
  logic signed [W-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic                out_x, out_y, out_z;

  rbsi_lane #(.COORD_BITS(COORD_BITS)) u_lane_x (
    .clk(clk), .center(center_x), .half(half_x), .origin(origin_x), .dir(dir_x),
    .t_lo(lo_x), .t_hi(hi_x), .outside(out_x)
  );
  rbsi_lane #(.COORD_BITS(COORD_BITS)) u_lane_y (
    .clk(clk), .center(center_y), .half(half_y), .origin(origin_y), .dir(dir_y),
    .t_lo(lo_y), .t_hi(hi_y), .outside(out_y)
  );
  rbsi_lane #(.COORD_BITS(COORD_BITS)) u_lane_z (
    .clk(clk), .center(center_z), .half(half_z), .origin(origin_z), .dir(dir_z),
    .t_lo(lo_z), .t_hi(hi_z), .outside(out_z)
  );

  // request tracking and limit delay
  logic         vld [NB+5];
  logic [W-1:0] lim [NB+4];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NB + 5; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= start & ~busy;
      for (int i = 1; i < NB + 5; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    lim[0] <= max_distance;
    for (int i = 1; i < NB + 4; i++) lim[i] <= lim[i-1];
  end

  // merge
  logic signed [W-1:0] tn_xy, tf_xy, tn, tf, lim_s;
  logic                miss;

  always_ff @(posedge clk) begin
    tn_xy <= (lo_x > lo_y) ? lo_x : lo_y;
    tf_xy <= (hi_x < hi_y) ? hi_x : hi_y;
  end

  logic signed [W-1:0] lo_z_d, hi_z_d;
  logic                out_d;

  always_ff @(posedge clk) begin
    lo_z_d <= lo_z;
    hi_z_d <= hi_z;
    out_d  <= out_x | out_y | out_z;
  end

  assign tn    = (tn_xy > lo_z_d) ? tn_xy : lo_z_d;
  assign tf    = (tf_xy < hi_z_d) ? tf_xy : hi_z_d;
  assign miss  = out_d;
  assign lim_s = $signed(lim[NB+3]);

  logic hit_next;

  always_comb begin
    hit_next = !miss && !(tn > tf) && !tf[W-1] && (tn < lim_s);
  end

  always_ff @(posedge clk) begin
    hit          <= hit_next;
    hit_distance <= !hit_next ? lim_s : ((tn > 0) ? tn : tf);
  end

  assign done = vld[NB+4];

  // checks
  a_done_lat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without request");

  a_hit_pos: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> !hit_distance[W-1])
    else $error("negative hit distance");

  a_miss_lim: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (hit_distance == $past(max_distance, LAT)))
    else $error("miss does not return limit");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ray_box_slab_intersect_unit.
// Loads a series of boxes over APB, from the reset box to the extremes of
// the register ranges, and sends directed and/or random rays per box, with
// random gaps between requests on most boxes. A behavioral slab tracer
// predicts each result; the bench checks each done strobe against it in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CB      = 32;
  localparam int LATENCY = CB + 22;
  localparam longint TMAX = 64'sd2147483647;
  localparam longint TMIN = -64'sd2147483648;

  typedef struct {
    logic signed [CB-1:0] org [3];
    logic signed [CB-1:0] dir [3];
    logic signed [CB-1:0] lim;
  } ray_t;

  typedef struct {
    logic                 hit;
    logic signed [CB-1:0] hit_dist;
  } trace_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 0;
  logic busy, done, hit;
  logic signed [CB-1:0] org_x = 0, org_y = 0, org_z = 0;
  logic signed [CB-1:0] dir_x = 0, dir_y = 0, dir_z = 0, lim = 0;
  logic signed [CB-1:0] hit_distance;

  ray_box_slab_intersect_unit dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .origin_x(org_x), .origin_y(org_y), .origin_z(org_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z), .max_distance(lim),
    .done(done), .hit(hit), .hit_distance(hit_distance)
  );

  initial forever #6 clk = ~clk;

  // box shadow
  longint box_c [3] = '{0, 0, 0};
  longint box_h [3] = '{0, 0, 0};

  ray_t   ray_q [$];
  trace_t trace_q [$];
  ray_t   cur;
  bit     taken = 0;
  bit     no_gap = 0;
  int     gap_cnt = 0;
  int     n_err = 0, n_checked = 0, n_hits = 0, n_boxes = 0;

  function automatic longint slab_div(longint num, longint den);
    longint q;
    q = (num * 65536) / den;
    if (q > TMAX) q = TMAX;
    if (q < TMIN) q = TMIN;
    return q;
  endfunction

  function automatic trace_t trace_ray(ray_t r);
    trace_t res;
    longint t_near, t_far, e, hs, ls, t1, t2, f, lmt;
    bit h;
    t_near = TMIN;
    t_far = TMAX;
    lmt = longint'(r.lim);
    h = 1;
    for (int ax = 0; ax < 3; ax++) begin
      if (h) begin
        e = box_c[ax] - longint'(r.org[ax]);
        hs = e + box_h[ax];
        ls = e - box_h[ax];
        f = longint'(r.dir[ax]);
        if (f != 0) begin
          t1 = slab_div(hs, f);
          t2 = slab_div(ls, f);
          if (t1 > t2) begin
            e = t1; t1 = t2; t2 = e;
          end
          if (t1 > t_near) t_near = t1;
          if (t2 < t_far) t_far = t2;
          if (t_near > t_far || t_far < 0) h = 0;
        end else if (hs < 0 || ls > 0) begin
          h = 0;
        end
        if (h && t_near >= lmt) h = 0;
      end
    end
    res.hit = h;
    res.hit_dist = h ? ((t_near > 0) ? t_near[CB-1:0] : t_far[CB-1:0]) : r.lim;
    return res;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (start && !taken) begin
      start <= 1;
    end else if (gap_cnt > 0) begin
      start <= 0;
      gap_cnt <= gap_cnt - 1;
    end else if (ray_q.size() > 0 && !rst) begin
      cur = ray_q.pop_front();
      org_x <= cur.org[0]; org_y <= cur.org[1]; org_z <= cur.org[2];
      dir_x <= cur.dir[0]; dir_y <= cur.dir[1]; dir_z <= cur.dir[2];
      lim <= cur.lim;
      start <= 1;
      gap_cnt <= no_gap ? 0 : $urandom_range(0, 9);
    end else begin
      start <= 0;
    end
    taken = 0;
  end

  // acceptance and result monitor
  always @(posedge clk) begin
    trace_t exp_r;
    if (!rst && start && !busy) begin
      trace_q.push_back(trace_ray(cur));
      taken = 1;
    end
    if (!rst && done) begin
      if (trace_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result hit=%0b dist=%h", hit, hit_distance);
      end else begin
        exp_r = trace_q.pop_front();
        n_checked++;
        if (exp_r.hit) n_hits++;
        if (hit !== exp_r.hit || hit_distance !== exp_r.hit_dist) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: expected hit=%0b dist=%h, got hit=%0b dist=%h",
                     exp_r.hit, exp_r.hit_dist, hit, hit_distance);
        end
      end
    end
  end

  task automatic apb_write(rbsi_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= 5'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    while (ray_q.size() != 0 || start || trace_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
  endtask

  task automatic load_box(longint cx, longint cy, longint cz,
                          longint hx, longint hy, longint hz);
    drain();
    apb_write(rbsi_pkg::REG_CENTER_X, 32'(cx));
    apb_write(rbsi_pkg::REG_CENTER_Y, 32'(cy));
    apb_write(rbsi_pkg::REG_CENTER_Z, 32'(cz));
    apb_write(rbsi_pkg::REG_HALF_X, 32'(hx) & 32'h7fffffff);
    apb_write(rbsi_pkg::REG_HALF_Y, 32'(hy) & 32'h7fffffff);
    apb_write(rbsi_pkg::REG_HALF_Z, 32'(hz) & 32'h7fffffff);
    box_c = '{longint'(signed'(32'(cx))), longint'(signed'(32'(cy))),
              longint'(signed'(32'(cz)))};
    box_h = '{hx & 32'h7fffffff, hy & 32'h7fffffff, hz & 32'h7fffffff};
    n_boxes++;
  endtask

  task automatic send(longint ox, longint oy, longint oz,
                      longint dx, longint dy, longint dz, longint lm);
    ray_t r;
    r.org = '{32'(ox), 32'(oy), 32'(oz)};
    r.dir = '{32'(dx), 32'(dy), 32'(dz)};
    r.lim = 32'(lm);
    ray_q.push_back(r);
  endtask

  function automatic longint rnd_dir();
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) return 0;
    if (k < 8) return longint'($urandom_range(0, 32'h40000)) - 32'h20000;
    return longint'(signed'($urandom()));
  endfunction

  task automatic random_rays(int cnt);
    longint o [3];
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send(signed'($urandom()), signed'($urandom()), signed'($urandom()),
             signed'($urandom()), signed'($urandom()), signed'($urandom()),
             signed'($urandom()));
      end else begin
        for (int a = 0; a < 3; a++)
          o[a] = box_c[a] + (longint'($urandom_range(0, 8)) - 4) * (box_h[a] / 2 + 1)
                 + longint'($urandom_range(0, 32'h20000)) - 32'h10000;
        send(o[0], o[1], o[2], rnd_dir(), rnd_dir(), rnd_dir(),
             ($urandom_range(0, 4) == 0) ? TMAX :
             longint'($urandom_range(0, 32'h4000000)) - 32'h100000);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst = 0;

    // reset box: a point at the origin
    send(0, 0, 0, 0, 0, 0, 1);
    send(0, 0, 0, 0, 0, 0, 0);
    send(32'h10000, 0, 0, 0, 0, 0, TMAX);
    send(-32'h10000, 0, 0, 32'h10000, 0, 0, TMAX);

    load_box(0, 0, 0, 32'h10000, 32'h10000, 32'h10000);
    send(0, 0, 0, 0, 0, 0, TMAX);                        // inside, parallel
    send(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, TMAX); // inside, exit distance
    send(-32'h50000, 0, 0, 32'h10000, 0, 0, TMAX);        // entry ahead
    send(-32'h50000, 0, 0, 32'h10000, 0, 0, 32'h40000);   // entry at limit
    send(-32'h50000, 0, 0, 32'h10000, 0, 0, TMIN);
    send(32'h50000, 0, 0, 32'h10000, 0, 0, TMAX);         // box behind
    send(0, 32'h20000, 0, 32'h10000, 0, 0, TMAX);         // parallel outside
    send(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, TMIN, TMIN, TMIN, TMAX);
    send(TMIN, TMIN, TMIN, TMAX, TMAX, TMAX, TMAX);
    send(TMIN, 0, 0, 1, 0, 0, TMAX);                      // quotient saturates
    send(TMAX, 0, 0, -1, 0, 0, TMAX);
    send(-32'h20000, -32'h20000, -32'h20000, 1, 1, 1, TMAX);
    send(32'h8000, 0, 0, -32'h10000, 32'h1, -32'h1, 0);
    send(32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 32'h1); // on the faces
    send(-32'hffffffff, 32'h5555aaaa, 32'haaaa5555, 32'h5555aaaa, 32'haaaa5555, 1, -1);

    load_box(TMAX, TMIN, TMAX, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send(0, 0, 0, 0, 0, 0, TMAX);
    send(TMIN, TMAX, TMIN, TMAX, TMIN, TMAX, TMAX);
    random_rays(30);

    load_box(TMIN, TMAX, TMIN, 0, 0, 0);
    send(TMIN, TMAX, TMIN, 0, 0, 0, TMAX);
    random_rays(30);

    for (int b = 0; b < 8; b++) begin
      no_gap = (b % 3 == 2);
      load_box(longint'($urandom_range(0, 32'hc80000)) - 32'h640000,
               longint'($urandom_range(0, 32'hc80000)) - 32'h640000,
               longint'($urandom_range(0, 32'hc80000)) - 32'h640000,
               $urandom_range(0, 32'h320000), $urandom_range(0, 32'h320000),
               $urandom_range(0, 32'h320000));
      random_rays(80);
    end
    no_gap = 0;
    load_box(signed'($urandom()), signed'($urandom()), signed'($urandom()),
             $urandom(), $urandom(), $urandom());
    random_rays(20);

    drain();
    $display("checked %0d rays (%0d hits) over %0d box settings", n_checked, n_hits,
             n_boxes);
    if (n_err == 0) begin
      $display("** ray_box_slab_intersect_unit: PASSED **");
    end else begin
      $display("%0d mismatches", n_err);
      $display("** ray_box_slab_intersect_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout");
    $display("** ray_box_slab_intersect_unit: FAILED **");
    $finish;
  end

endmodule
